FILE: sv/bffa_pkg.sv
package bffa_pkg;

    // map geometry
    localparam int MAP_BITS    = 4096;
    localparam int WORD_BITS   = 64;
    localparam int MAP_WORDS   = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // field widths
    localparam int IDX_W       = 12;
    localparam int LIM_W       = 13;
    localparam int PTR_W       = IDX_W - BIT_W;
    localparam int GRANT_SPAN  = 4096;
    localparam int SEARCH_SPAN = (MAP_BITS < GRANT_SPAN) ? MAP_BITS : GRANT_SPAN;

    // lowest-zero search split into groups of eight bits
    localparam int GROUP_BITS  = 8;
    localparam int GROUPS      = WORD_BITS / GROUP_BITS;
    localparam int SUB_W       = $clog2(GROUP_BITS);

    // configuration port
    localparam int PADDR_W     = 3;
    localparam int DATA_W      = 32;
    localparam logic [0:0] REG_FIRST = 1'b0;
    localparam logic [0:0] REG_LIMIT = 1'b1;
    localparam logic [IDX_W-1:0] FIRST_RESET = 12'd70;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 13'd4096;

    // request kinds and status codes
    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_FREE   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_find_res;

endpackage

FILE: sv/bitmap_first_free_allocator.sv
// first-fit bitmap allocator
// requests: raise start with i_kind and i_free_index; the transaction is taken
// at a clock edge where start is high and busy is low
// allocate (i_kind 0) grants the lowest clear bit in [first_index, min(limit, 4096)) and
// sets it; free (i_kind 1) clears the named bit, set or not
// every transaction gives exactly one result, shown for one cycle with o_valid;
// the receiver cannot stall, so results never wait
// the map lives in a 64 x 64 synchronous ram, one word read per cycle
// allocate: scans the window one ram word per cycle, up to 64 words, and on a
// grant sets the bit and writes the word back; otherwise it reports out of space
// free: read, modify, write back; a free beyond the map or an empty search window
// answers straight from idle, without a ram access
// a new request is accepted in the cycle its predecessor's result is shown
// reset: synchronous, active low; per-word valid flops clear at once, so the
// map reads as all free right after reset with no clearing pass; first_index
// resets to 70 and index_limit to 4096
// config: apb registers first_index at 0x0, index_limit at 0x4, pready tied high
module bitmap_first_free_allocator
    import bffa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_free_index,
    // result channel
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_granted_index,
    output logic               o_status,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_FREE   = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    // widen a word pointer to a ram address (or trim it on small maps)
    function automatic logic [ADDR_W-1:0] to_addr(input logic [PTR_W-1:0] p);
        logic [ADDR_W+PTR_W-1:0] t;
        t = {{ADDR_W{1'b0}}, p};
        return t[ADDR_W-1:0];
    endfunction

    // configuration registers
    logic [IDX_W-1:0]  r_first_index;
    logic [LIM_W-1:0]  r_index_limit;

    // control
    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [BIT_W-1:0]  r_free_b, n_free_b;
    logic [IDX_W-1:0]  r_grant, n_grant;
    t_word             r_wr_word, n_wr_word;

    // result registers
    logic              r_valid, n_valid;
    logic [IDX_W-1:0]  r_gidx, n_gidx;
    logic              r_status, n_status;

    // map storage
    t_word             r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_row_vld;
    t_word             r_rd_data;
    logic              r_rd_vld;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    // search window
    logic [LIM_W-1:0]  bound;
    logic [LIM_W-1:0]  last_idx;
    logic              window_ok;
    logic [PTR_W-1:0]  first_w, last_w;
    logic [BIT_W-1:0]  first_b, last_b;
    logic              free_ok;

    // scan datapath
    t_word             eff_word;
    t_word             lo_mask, hi_mask, masked;
    t_find_res         find;

    // ---------------------------------------------------------------
    // configuration port: write only while idle; the block itself does not enforce it
    // ---------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_index <= FIRST_RESET;
            r_index_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_FIRST: r_first_index <= pwdata[IDX_W-1:0];
                REG_LIMIT: r_index_limit <= pwdata[LIM_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FIRST: prdata = DATA_W'(r_first_index);
            REG_LIMIT: prdata = DATA_W'(r_index_limit);
            default:   prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // search window: bound is the smaller of the limit and the span
    // ---------------------------------------------------------------
    assign bound     = (r_index_limit > LIM_W'(SEARCH_SPAN)) ? LIM_W'(SEARCH_SPAN)
                                                             : r_index_limit;
    assign window_ok = ({1'b0, r_first_index} < bound);
    assign last_idx  = bound - LIM_W'(1);
    assign first_w   = r_first_index[IDX_W-1:BIT_W];
    assign first_b   = r_first_index[BIT_W-1:0];
    assign last_w    = last_idx[IDX_W-1:BIT_W];
    assign last_b    = last_idx[BIT_W-1:0];
    assign free_ok   = (32'(i_free_index) < 32'(MAP_BITS));

    // ---------------------------------------------------------------
    // map ram: one read and one write port, registered read data;
    // a word whose valid flop is clear reads as all free
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= r_wr_word;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
        end
    end

    assign eff_word = r_rd_vld ? r_rd_data : '0;
    assign wr_en    = (r_state == ST_COMMIT);
    assign wr_addr  = to_addr(r_ptr);

    // bits outside the window count as taken
    assign lo_mask = (r_ptr == first_w) ? ~({WORD_BITS{1'b1}} << first_b) : '0;
    assign hi_mask = (r_ptr == last_w)
                   ? ~({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - last_b)) : '0;
    assign masked  = eff_word | lo_mask | hi_mask;

    bffa_find u_find (
        .i_word (masked),
        .o_res  (find)
    );

    // ---------------------------------------------------------------
    // sequencer: read, scan word by word (allocate only), modify, write back
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_free_b  = r_free_b;
        n_grant   = r_grant;
        n_wr_word = r_wr_word;
        n_valid   = 1'b0;
        n_gidx    = r_gidx;
        n_status  = r_status;
        rd_en     = 1'b0;
        rd_addr   = to_addr(r_ptr);

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_FREE) begin
                        if (free_ok) begin
                            n_ptr    = i_free_index[IDX_W-1:BIT_W];
                            n_free_b = i_free_index[BIT_W-1:0];
                            rd_en    = 1'b1;
                            rd_addr  = to_addr(i_free_index[IDX_W-1:BIT_W]);
                            n_state  = ST_FREE;
                        end else begin
                            // beyond the map: ignored, plain ok result
                            n_valid  = 1'b1;
                            n_gidx   = '0;
                            n_status = STATUS_OK;
                        end
                    end else if (window_ok) begin
                        n_ptr   = first_w;
                        rd_en   = 1'b1;
                        rd_addr = to_addr(first_w);
                        n_state = ST_SCAN;
                    end else begin
                        // empty window fails at once
                        n_valid  = 1'b1;
                        n_gidx   = '0;
                        n_status = STATUS_FULL;
                    end
                end
            end

            ST_SCAN: begin
                if (find.found) begin
                    n_wr_word = eff_word | (t_word'(1) << find.pos);
                    n_grant   = {r_ptr, find.pos};
                    n_state   = ST_COMMIT;
                end else if (r_ptr == last_w) begin
                    n_valid  = 1'b1;
                    n_gidx   = '0;
                    n_status = STATUS_FULL;
                    n_state  = ST_IDLE;
                end else begin
                    // next word read overlaps the check of this one
                    n_ptr   = r_ptr + PTR_W'(1);
                    rd_en   = 1'b1;
                    rd_addr = to_addr(r_ptr + PTR_W'(1));
                end
            end

            ST_FREE: begin
                n_wr_word = eff_word & ~(t_word'(1) << r_free_b);
                n_grant   = '0;
                n_state   = ST_COMMIT;
            end

            ST_COMMIT: begin
                n_valid  = 1'b1;
                n_gidx   = r_grant;
                n_status = STATUS_OK;
                n_state  = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_free_b  <= n_free_b;
        r_grant   <= n_grant;
        r_wr_word <= n_wr_word;
        r_gidx    <= n_gidx;
        r_status  <= n_status;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_granted_index = r_gidx;
    assign o_status        = r_status;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_fail_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_FULL) |-> (o_granted_index == '0))
        else $error("failed allocation carries a nonzero index");

    a_commit_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |=> (r_state == ST_IDLE && o_valid))
        else $error("write-back not followed by a result");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted transaction produced neither work nor result");

    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_ptr <= last_w && r_ptr >= first_w))
        else $error("scan pointer left the search window");

endmodule

FILE: sv/bffa_find.sv
module bffa_find
    import bffa_pkg::*;
(
    input  t_word     i_word,
    output t_find_res o_res
);

    logic [GROUPS-1:0] grp_has;
    logic [SUB_W-1:0]  grp_pos [GROUPS];

    // lowest zero inside each group of eight
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_has[g] = 1'b0;
            grp_pos[g] = '0;
            for (int j = GROUP_BITS - 1; j >= 0; j--) begin
                if (!i_word[g*GROUP_BITS + j]) begin
                    grp_has[g] = 1'b1;
                    grp_pos[g] = SUB_W'(j);
                end
            end
        end
    end

    // lowest group that has a zero
    always_comb begin
        o_res.found = 1'b0;
        o_res.pos   = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (grp_has[g]) begin
                o_res.found = 1'b1;
                o_res.pos   = BIT_W'(g*GROUP_BITS) | BIT_W'(grp_pos[g]);
            end
        end
    end

endmodule

FILE: tb/sv/bffa_checker.sv
`timescale 1ns / 1ps

module bffa_checker
    import bffa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_kind,
    input  logic [IDX_W-1:0]   i_free_index,
    input  logic               i_valid,
    input  logic [IDX_W-1:0]   i_granted_index,
    input  logic               i_status,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0]  i_pwdata,
    input  logic               i_pready,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             status;
    } t_grant;

    logic             in_use [0:MAP_BITS-1];
    logic [IDX_W-1:0] first_reg;
    logic [LIM_W-1:0] limit_reg;
    t_grant           expected_grants [$];
    int               error_count = 0;
    int               pending_count = 0;

    assign o_errors  = error_count;
    assign o_pending = pending_count;

    // first-fit search over [first_reg, min(limit, map, grant span))
    function automatic t_grant predict_grant(logic kind, logic [IDX_W-1:0] idx);
        t_grant g;
        int     bound;
        int     i;
        logic   found;
        g.index = '0;
        g.status = STATUS_OK;
        if (kind == KIND_FREE) begin
            if (idx < MAP_BITS)
                in_use[idx] = 1'b0;
            return g;
        end
        bound = limit_reg;
        if (bound > MAP_BITS)
            bound = MAP_BITS;
        if (bound > GRANT_SPAN)
            bound = GRANT_SPAN;
        found = 1'b0;
        for (i = first_reg; i < bound && !found; i++) begin
            if (!in_use[i]) begin
                in_use[i] = 1'b1;
                g.index = i[IDX_W-1:0];
                found = 1'b1;
            end
        end
        if (!found)
            g.status = STATUS_FULL;
        return g;
    endfunction

    always @(posedge i_clk) begin : watch
        t_grant want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAP_BITS; k++)
                in_use[k] = 1'b0;
            first_reg = FIRST_RESET;
            limit_reg = LIMIT_RESET;
            expected_grants.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1:2] == REG_FIRST)
                    first_reg = i_pwdata[IDX_W-1:0];
                else if (i_paddr[PADDR_W-1:2] == REG_LIMIT)
                    limit_reg = i_pwdata[LIM_W-1:0];
            end
            if (i_valid) begin
                if (expected_grants.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result, index %0d status %0d",
                                 $realtime, i_granted_index, i_status);
                end else begin
                    want = expected_grants.pop_front();
                    if (want.index !== i_granted_index || want.status !== i_status) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: mismatch, exp idx %0d st %0d, got idx %0d st %0d",
                                     $realtime, want.index, want.status,
                                     i_granted_index, i_status);
                    end
                end
            end
            if (i_start && !i_busy)
                expected_grants.push_back(predict_grant(i_kind, i_free_index));
        end
        pending_count = expected_grants.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bffa_pkg::*;

    // run shape: ten phases of random transactions, each under its own window
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 75;
    // worst case is far below this
    localparam int CYCLE_LIMIT     = 500000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_kind = KIND_ALLOC;
    logic [IDX_W-1:0]   i_free_index = '0;
    logic               o_valid;
    logic [IDX_W-1:0]   o_granted_index;
    logic               o_status;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 error_total;
    int                 pending_total;
    int unsigned        cycle_count = 0;

    // current search window, kept here only to aim frees at it
    int                 win_first = 70;
    int                 win_limit = 4096;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bitmap_first_free_allocator DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_free_index    (i_free_index),
        .o_valid         (o_valid),
        .o_granted_index (o_granted_index),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // watches both channels and the register port, predicts and compares
    bffa_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_kind          (i_kind),
        .i_free_index    (i_free_index),
        .i_valid         (o_valid),
        .i_granted_index (o_granted_index),
        .i_status        (o_status),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_errors        (error_total),
        .o_pending       (pending_total)
    );

    // watchdog: a hung handshake or a lost result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // one transaction; called just after a falling edge, returns just after one, once the request is taken
    task automatic request(input logic kind, input logic [IDX_W-1:0] idx);
        start = 1'b1;
        i_kind = kind;
        i_free_index = idx;
        // taken at the rising edge where busy is low
        do
            @(posedge i_clk);
        while (busy);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // wait until every outstanding transaction has its result
    task automatic drain();
        while (pending_total != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // apb write: setup, then access until pready
    task automatic reg_write(input logic [0:0] reg_sel, input int value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_sel, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // registers only move while the allocator is idle
    task automatic set_window(input int first, input int limit);
        drain();
        reg_write(REG_FIRST, first);
        reg_write(REG_LIMIT, limit);
        win_first = first;
        win_limit = limit;
    endtask

    // free target: half anywhere, half under 200 past the window start
    function automatic logic [IDX_W-1:0] pick_free_index();
        int span;
        if ($urandom_range(0, 1) == 0)
            return IDX_W'($urandom_range(0, 4095));
        span = (win_limit > win_first) ? win_limit - win_first : 1;
        if (span > 200)
            span = 200;
        return IDX_W'((win_first + $urandom_range(0, span - 1)) % 4096);
    endfunction

    initial begin : stimulus
        int   first;
        int   limit;
        int   alloc_pct;
        logic idle_on;

        // reset held low at the start, never again
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: reset window 70..4096
        request(KIND_ALLOC, '0);
        request(KIND_ALLOC, '0);
        request(KIND_FREE, 12'd70);
        request(KIND_ALLOC, '0);
        // freeing bits that were never set
        request(KIND_FREE, 12'd0);
        request(KIND_FREE, 12'd4095);

        // top of the map only
        set_window(4095, 4096);
        request(KIND_ALLOC, '0);
        request(KIND_ALLOC, '0);
        request(KIND_FREE, 12'd4095);
        request(KIND_ALLOC, '0);

        // empty window at zero
        set_window(0, 0);
        request(KIND_ALLOC, '0);
        request(KIND_FREE, 12'd4095);

        // limit past the end of the map
        set_window(0, 8191);
        request(KIND_ALLOC, '0);
        request(KIND_ALLOC, '0);
        request(KIND_FREE, 12'd1);
        request(KIND_ALLOC, '0);

        // limit below first
        set_window(200, 100);
        request(KIND_ALLOC, '0);

        // two-slot window running out
        set_window(3, 5);
        request(KIND_ALLOC, '0);
        request(KIND_ALLOC, '0);
        request(KIND_ALLOC, '0);
        request(KIND_FREE, 12'd3);
        request(KIND_ALLOC, '0);

        // random phases, each under its own window
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                first = 0;
                limit = 4096;
            end else if (p == 1) begin
                first = 4000;
                limit = 8191;
            end else if (p == PHASES - 1) begin
                first = 70;
                limit = 4096;
            end else if ($urandom_range(0, 3) != 0) begin
                // narrow windows fill up and report out of space
                first = $urandom_range(0, 4095);
                limit = first + $urandom_range(1, 48);
            end else begin
                first = $urandom_range(0, 4095);
                limit = $urandom_range(0, 8191);
            end
            set_window(first, limit);
            alloc_pct = $urandom_range(50, 80);
            // the last phase runs back to back, others mostly with gaps
            idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 16)) @(negedge i_clk);
                // in phase 3, hold off mid-phase until the allocator has gone quiet
                if (p == 3 && n == ITEMS_PER_PHASE / 2)
                    drain();
                if ($urandom_range(0, 99) < alloc_pct)
                    request(KIND_ALLOC, IDX_W'($urandom_range(0, 4095)));
                else
                    request(KIND_FREE, pick_free_index());
            end
        end

        // let the last results come home, then watch for strays
        drain();
        repeat (80) @(negedge i_clk);

        if (error_total == 0 && pending_total == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
